// ===== src/i2ew_pkg.sv =====
package i2ew_pkg;

    localparam int unsigned VALUE_W = 31;
    localparam int unsigned TOK_W   = 5;
    localparam int unsigned NDIG    = 10;
    localparam int unsigned NGRP    = 4;
    localparam int unsigned NPH     = 5;
    localparam int unsigned NPOS    = NGRP * NPH;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned CNT_W   = 5;

    localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(VALUE_W - 1);

    localparam logic [TOK_W-1:0] TOK_TEN      = 5'd10;
    localparam logic [TOK_W-1:0] TOK_TWENTY   = 5'd20;
    localparam logic [TOK_W-1:0] TOK_HUNDRED  = 5'd28;
    localparam logic [TOK_W-1:0] TOK_THOUSAND = 5'd29;
    localparam logic [TOK_W-1:0] TOK_MILLION  = 5'd30;
    localparam logic [TOK_W-1:0] TOK_BILLION  = 5'd31;

    // Slot of a word inside one three-digit group.
    localparam int unsigned PH_HDIG  = 0;
    localparam int unsigned PH_HWORD = 1;
    localparam int unsigned PH_TENS  = 2;
    localparam int unsigned PH_ONES  = 3;
    localparam int unsigned PH_SCALE = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_FIND,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
        logic first;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic conv_last;
        logic is_last;
        logic out_free;
    } t_status;

endpackage

// ===== src/i2ew_ctrl.sv =====
module i2ew_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  i2ew_pkg::t_status i_status,
    output i2ew_pkg::t_cmd    o_cmd,
    output logic              o_idle
);
    import i2ew_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_idle  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.shift = 1'b1;
                if (i_status.conv_last) begin
                    n_state = ST_FIND;
                end
            end
            ST_FIND: begin
                o_cmd.first = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    if (i_status.is_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/i2ew_dp.sv =====
module i2ew_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  i2ew_pkg::t_cmd                   i_cmd,
    input  logic [i2ew_pkg::VALUE_W-1:0]     i_value,
    input  logic                             i_out_ready,
    output i2ew_pkg::t_status                o_status,
    output logic                             o_out_valid,
    output logic [i2ew_pkg::TOK_W-1:0]       o_out_tok,
    output logic                             o_out_last
);
    import i2ew_pkg::*;

    logic [VALUE_W-1:0] r_bin;
    logic [3:0]         r_dig [NDIG];
    logic [3:0]         adj   [NDIG];
    logic [CNT_W-1:0]   r_cnt;
    logic [POS_W-1:0]   r_pos;
    logic               r_out_valid;
    logic [TOK_W-1:0]   r_out_tok;
    logic               r_out_last;

    logic [3:0]         g_h   [NGRP];
    logic [3:0]         g_t   [NGRP];
    logic [3:0]         g_o   [NGRP];
    logic [TOK_W-1:0]   g_sc  [NGRP];
    logic [TOK_W-1:0]   tok   [NPOS];
    logic [NPOS-1:0]    mask;
    logic [NPOS-1:0]    higher;
    logic [POS_W-1:0]   first_pos;
    logic [POS_W-1:0]   next_pos;
    logic               all_zero;

    // Shift-and-add-three binary to decimal conversion, one bit per cycle.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            adj[i] = (r_dig[i] >= 4'd5) ? r_dig[i] + 4'd3 : r_dig[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= i_value;
            for (int i = 0; i < NDIG; i++) begin
                r_dig[i] <= 4'd0;
            end
        end else if (i_cmd.shift) begin
            r_bin    <= {r_bin[VALUE_W-2:0], 1'b0};
            r_dig[0] <= {adj[0][2:0], r_bin[VALUE_W-1]};
            for (int i = 1; i < NDIG; i++) begin
                r_dig[i] <= {adj[i][2:0], adj[i-1][3]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.shift) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Groups: billions, millions, thousands, units.
    always_comb begin
        g_h[0] = 4'd0;      g_t[0] = 4'd0;      g_o[0] = r_dig[9];
        g_h[1] = r_dig[8];  g_t[1] = r_dig[7];  g_o[1] = r_dig[6];
        g_h[2] = r_dig[5];  g_t[2] = r_dig[4];  g_o[2] = r_dig[3];
        g_h[3] = r_dig[2];  g_t[3] = r_dig[1];  g_o[3] = r_dig[0];
        g_sc[0] = TOK_BILLION;
        g_sc[1] = TOK_MILLION;
        g_sc[2] = TOK_THOUSAND;
        g_sc[3] = TOK_HUNDRED;
        all_zero = 1'b1;
        for (int i = 0; i < NDIG; i++) begin
            if (r_dig[i] != 4'd0) begin
                all_zero = 1'b0;
            end
        end
    end

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            tok[g*NPH + PH_HDIG]  = {1'b0, g_h[g]};
            tok[g*NPH + PH_HWORD] = TOK_HUNDRED;
            if (g_t[g] >= 4'd2) begin
                tok[g*NPH + PH_TENS] = TOK_TWENTY + {1'b0, g_t[g]} - 5'd2;
            end else if (g_t[g] == 4'd1) begin
                tok[g*NPH + PH_TENS] = TOK_TEN + {1'b0, g_o[g]};
            end else begin
                tok[g*NPH + PH_TENS] = {1'b0, g_o[g]};
            end
            tok[g*NPH + PH_ONES]  = {1'b0, g_o[g]};
            tok[g*NPH + PH_SCALE] = g_sc[g];

            mask[g*NPH + PH_HDIG]  = (g_h[g] != 4'd0);
            mask[g*NPH + PH_HWORD] = (g_h[g] != 4'd0);
            mask[g*NPH + PH_TENS]  = (g_t[g] != 4'd0) || (g_o[g] != 4'd0);
            mask[g*NPH + PH_ONES]  = (g_t[g] >= 4'd2) && (g_o[g] != 4'd0);
            mask[g*NPH + PH_SCALE] = (g < NGRP - 1) &&
                ((g_h[g] != 4'd0) || (g_t[g] != 4'd0) || (g_o[g] != 4'd0));
        end
        // A zero value is spelled by the units tens slot, whose token is then Zero.
        if (all_zero) begin
            mask[(NGRP-1)*NPH + PH_TENS] = 1'b1;
        end
    end

    always_comb begin
        first_pos = '0;
        next_pos  = '0;
        for (int k = NPOS - 1; k >= 0; k--) begin
            higher[k] = mask[k] && (POS_W'(k) > r_pos);
            if (mask[k]) begin
                first_pos = POS_W'(k);
            end
            if (higher[k]) begin
                next_pos = POS_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_cmd.first) begin
            r_pos <= first_pos;
        end else if (i_cmd.push) begin
            r_pos <= next_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_tok  <= tok[r_pos];
            r_out_last <= (higher == '0);
        end
    end

    assign o_status.conv_last = (r_cnt == CONV_LAST);
    assign o_status.is_last   = (higher == '0);
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_tok          = r_out_tok;
    assign o_out_last         = r_out_last;

endmodule

// ===== src/integer_to_english_word_tokens_core.sv =====
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid/s_axis_tready    tdata[30:0] value
// m_axis   out  m_axis_tvalid/m_axis_tready    tdata[4:0] word_token, tlast last_word
//
// One number is loaded, converted bit-serially from binary to decimal and its
// first word located; then words follow one per cycle while the output is not
// stalled (1 to 16 words).
// The next number is taken once the last word sits in the output register.
// Reset is synchronous, active low, and clears the controller and output valid.
// A stalled output holds the word and pauses word generation.
module integer_to_english_word_tokens_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] value, [31] ignored
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [4:0] word_token, [7:5] zero fill
    output logic        m_axis_tlast
);
    import i2ew_pkg::*;

    t_cmd             cmd;
    t_status          status;
    logic             idle;
    logic [TOK_W-1:0] out_tok;

    i2ew_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (s_axis_tvalid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_idle   (idle)
    );

    i2ew_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (s_axis_tdata[VALUE_W-1:0]),
        .i_out_ready (m_axis_tready),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .o_out_tok   (out_tok),
        .o_out_last  (m_axis_tlast)
    );

    assign s_axis_tready = idle;
    assign m_axis_tdata  = {3'b000, out_tok};

endmodule

// ===== dv/word_token_checker.sv =====
`timescale 1ns / 100ps

module word_token_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [30:0] value, [31] ignored
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [7:0]  i_m_axis_tdata,   // [4:0] word_token, [7:5] zero fill
    input  logic        i_m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_numbers_seen,
    output int          o_words_seen
);
    import i2ew_pkg::*;

    localparam logic [TOK_W-1:0] TOK_ZERO = '0;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [TOK_W-1:0] token;
        logic             last;
    } t_word;

    t_word            expected_words[$];
    logic [TOK_W-1:0] spelled[$];
    t_word            want;
    int               fail_count   = 0;
    int               numbers_seen = 0;
    int               words_seen   = 0;

    // Spells one group in 1..999 without its scale word.
    function automatic void spell_group(input int unsigned grp);
        int unsigned rest;
        rest = grp % 100;
        if (grp >= 100) begin
            spelled.push_back(TOK_W'(grp / 100));
            spelled.push_back(TOK_HUNDRED);
        end
        if (rest >= 20) begin
            spelled.push_back(TOK_TWENTY + TOK_W'(rest / 10 - 2));
            if (rest % 10 != 0)
                spelled.push_back(TOK_W'(rest % 10));
        end else if (rest != 0) begin
            spelled.push_back(TOK_W'(rest));
        end
    endfunction

    function automatic void predict_words(input logic [VALUE_W-1:0] value);
        int unsigned      rem;
        int unsigned      grp;
        int unsigned      divisor;
        logic [TOK_W-1:0] scale;
        spelled.delete();
        rem = 32'(value);
        if (rem == 0) begin
            spelled.push_back(TOK_ZERO);
        end else begin
            for (int i = 0; i < 3; i++) begin
                case (i)
                    0: begin
                        divisor = 1000000000;
                        scale   = TOK_BILLION;
                    end
                    1: begin
                        divisor = 1000000;
                        scale   = TOK_MILLION;
                    end
                    default: begin
                        divisor = 1000;
                        scale   = TOK_THOUSAND;
                    end
                endcase
                grp = rem / divisor;
                rem = rem % divisor;
                if (grp != 0) begin
                    spell_group(grp);
                    spelled.push_back(scale);
                end
            end
            if (rem != 0)
                spell_group(rem);
        end
        foreach (spelled[k])
            expected_words.push_back('{token: spelled[k], last: (k == spelled.size() - 1)});
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_words(i_s_axis_tdata[VALUE_W-1:0]);
                numbers_seen++;
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    note_failure($sformatf("word token %0d last %0b arrived with none expected",
                                           i_m_axis_tdata[TOK_W-1:0], i_m_axis_tlast));
                end else begin
                    want = expected_words.pop_front();
                    if (i_m_axis_tdata[TOK_W-1:0] !== want.token || i_m_axis_tlast !== want.last)
                        note_failure($sformatf(
                            "word %0d: expected token %0d last %0b, got token %0d last %0b",
                            words_seen, want.token, want.last,
                            i_m_axis_tdata[TOK_W-1:0], i_m_axis_tlast));
                end
            end
        end
        // Outputs move with the clock so the stimulus side samples them without a race.
        o_fail_count   <= fail_count;
        o_pending      <= expected_words.size();
        o_numbers_seen <= numbers_seen;
        o_words_seen   <= words_seen;
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import i2ew_pkg::*;

    localparam int RANDOM_ITEMS = 460;
    localparam int NUM_CORNERS  = 24;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE       = 80;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [30:0] value, [31] ignored
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [4:0] word_token, [7:5] zero fill
    logic        m_axis_tlast;

    int   fail_count;
    int   pending;
    int   numbers_seen;
    int   words_seen;
    int   idle_cycles  = 0;
    logic tx_quiet     = 1'b0;
    logic hold_request = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    integer_to_english_word_tokens_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    word_token_checker words_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_numbers_seen  (numbers_seen),
        .o_words_seen    (words_seen)
    );

    // Numbers at the edges of the spelling rules; bit 31 is set on a few to show it is ignored.
    function automatic logic [31:0] corner_value(input int k);
        case (k)
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'd9;
            3:       return 32'd10;
            4:       return 32'd11;
            5:       return 32'd19;
            6:       return 32'd20;
            7:       return 32'd21;
            8:       return 32'd99;
            9:       return 32'd100;
            10:      return 32'd110;
            11:      return 32'd119;
            12:      return 32'd999;
            13:      return 32'd1000;
            14:      return 32'd1000000;
            15:      return 32'd1000000000;
            16:      return 32'd2000000000;
            17:      return 32'd1001001001;
            18:      return 32'd700000019;
            19:      return 32'd1000010;
            20:      return 32'd2147483647;
            21:      return 32'hFFFF_FFFF;
            22:      return 32'h8000_0000;
            default: return 32'd1777777777;
        endcase
    endfunction

    function automatic logic [31:0] random_value();
        longint v;
        longint p10;
        case ($urandom_range(0, 3))
            0: v = $urandom & 32'h7FFF_FFFF;
            1: v = $urandom_range(0, 999);
            2: begin
                // Build from groups so that zero groups in the middle are common.
                v = longint'($urandom_range(0, 2)) * 1000000000;
                if ($urandom_range(0, 1)) v += longint'($urandom_range(0, 999)) * 1000000;
                if ($urandom_range(0, 1)) v += longint'($urandom_range(0, 999)) * 1000;
                if ($urandom_range(0, 1)) v += $urandom_range(0, 999);
                if (v > 2147483647) v -= 1000000000;
            end
            default: begin
                p10 = 1;
                repeat ($urandom_range(1, 9)) p10 *= 10;
                v = $urandom % p10;
            end
        endcase
        return {($urandom_range(0, 7) == 0), 31'(v)};
    endfunction

    task automatic send_number(input logic [31:0] word);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drops valid and waits until every predicted word has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < NUM_CORNERS; k++)
            send_number(corner_value(k));
        wait_drained();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            tx_quiet = ((n / 40) % 3 == 1);
            if (n == 150)
                hold_request <= 1'b1;
            if (n == 320)
                wait_drained();
            send_number(random_value());
        end
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        $display("Spelled %0d numbers into %0d word tokens: corner values, mixed-size random",
                 numbers_seen, words_seen);
        $display("values, random stalls on both sides and one long output hold-off.");
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Output side: random stalls, quiet stretches, and one long hold-off on request.
    initial begin
        int unsigned stall;
        int          taken;
        logic        rx_quiet;
        logic        hold_done;
        taken     = 0;
        rx_quiet  = 1'b0;
        hold_done = 1'b0;
        forever begin
            if (hold_request && !hold_done) begin
                stall     = LONG_HOLD;
                hold_done = 1'b1;
            end else if (rx_quiet) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 11);
            end
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            taken++;
            if (taken % 64 == 0)
                rx_quiet = !rx_quiet;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timed out after %0d cycles with no transfer.", idle_cycles);
            $display("FAIL");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
src/i2ew_pkg.sv
src/i2ew_ctrl.sv
src/i2ew_dp.sv
src/integer_to_english_word_tokens_core.sv
dv/word_token_checker.sv
dv/tb.sv
